@@ rtl/plars_pkg.sv @@
// Shared types, constants and helpers for the polyline arc-length resampler.
// No dependencies; imported by every module of the block.
package plars_pkg;

  localparam int MaxNodes = 256;
  localparam int NodeAw   = 8;    // node store address bits
  localparam int CountW   = 9;    // node count, holds MaxNodes itself
  localparam int CoordW   = 32;
  localparam int SegW     = 33;   // one segment length, floor sqrt of < 2^66
  localparam int TotW     = 42;   // sum of all segment lengths
  localparam int NumW     = 48;   // j * total
  localparam int DvdW     = 64;   // iterative unit dividend
  localparam int RadW     = 66;   // iterative unit radicand
  localparam int FracBits = 30;
  localparam int PcW      = 7;
  localparam int JW       = 6;
  localparam logic [PcW-1:0] PcMin = 7'd2;
  localparam logic [PcW-1:0] PcMax = 7'd64;
  localparam logic [6:0] DivSteps  = 7'd64;
  localparam logic [6:0] SqrtSteps = 7'd33;

  typedef enum logic [1:0] {
    KIND_APPEND   = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_RESAMPLE = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_ctl_t;

  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } node_t;

  // magnitude of a component difference; fits 32 bits for 32-bit operands
  function automatic logic [CoordW-1:0] mag(input logic signed [CoordW:0] d);
    logic [CoordW:0] m;
    m = d[CoordW] ? (~d + 33'd1) : d;
    return m[CoordW-1:0];
  endfunction

endpackage

@@ rtl/plars_mul.sv @@
// Registered 32x32 unsigned multiplier shared by the resampler sequencer.
// Depends on plars_pkg.
module plars_mul (
  input  logic                              clk,
  input  logic [plars_pkg::CoordW-1:0]      a,
  input  logic [plars_pkg::CoordW-1:0]      b,
  output logic [2*plars_pkg::CoordW-1:0]    p
);
  import plars_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/plars_iter.sv @@
// Bit-serial divide / square-root unit: one quotient or root bit per cycle.
// Depends on plars_pkg.
module plars_iter (
  input  logic                         clk,
  input  logic                         rst,
  input  plars_pkg::iter_ctl_t         ctl,
  input  logic [plars_pkg::RadW-1:0]   a,
  input  logic [plars_pkg::SegW-1:0]   b,
  output logic                         done,
  output logic [plars_pkg::DvdW-1:0]   q
);
  import plars_pkg::*;

  logic            busy;
  iter_op_t        op_q;
  logic [6:0]      cnt;
  logic [DvdW-1:0] dvd;
  logic [SegW-1:0] rem;
  logic [SegW-1:0] dsr;
  logic [RadW-1:0] sop;
  logic [RadW-1:0] sres;
  logic [RadW-1:0] sone;

  logic [SegW:0]   rem_sh;
  logic            dge;
  logic [SegW:0]   rem_sub;
  logic [RadW-1:0] trial;
  logic            sge;

  assign rem_sh  = {rem, dvd[DvdW-1]};
  assign dge     = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign trial   = sres + sone;
  assign sge     = sop >= trial;
  assign q       = (op_q == OP_DIV) ? dvd : sres[DvdW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_q <= OP_SQRT;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op_q <= ctl.op;
        cnt  <= (ctl.op == OP_DIV) ? DivSteps : SqrtSteps;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd  <= a[DvdW-1:0];
      rem  <= '0;
      dsr  <= b;
      sop  <= a;
      sres <= '0;
      sone <= {2'b01, {(RadW-2){1'b0}}};
    end else if (busy) begin
      if (op_q == OP_DIV) begin
        rem <= dge ? rem_sub[SegW-1:0] : rem_sh[SegW-1:0];
        dvd <= {dvd[DvdW-2:0], dge};
      end else begin
        if (sge) begin
          sop  <= sop - trial;
          sres <= (sres >> 1) + sone;
        end else begin
          sres <= sres >> 1;
        end
        sone <= sone >> 2;
      end
    end
  end

endmodule

@@ rtl/polyline_arc_length_resample_top.sv @@
// Polyline arc-length resampler, top level: node store, sequencer, APB register.
// Depends on plars_pkg, plars_mul and plars_iter.
//
// Append beats (tuser 0) load a node; clear beats (tuser 1) empty the store;
// both give no output. A resample beat (tuser 2) emits point_count points
// (held to 2..64), evenly spaced by arc length, the final one marked by
// m_tlast; with fewer than two nodes it emits one zero point with tuser (error)
// and tlast set. The block takes one beat at a time and drops s_tready until a
// resample run is fully delivered. A run first takes the segment lengths
// (three squares on the shared multiplier plus a 33-step bit-serial square
// root), then for each middle point a 64-step divide for its distance, a walk
// over the segments, a 64-step divide for the fraction on the segment found
// and the interpolation.
module polyline_arc_length_resample_top (
  input  logic         clk,
  input  logic         rst,
  // stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  input  logic [1:0]   s_tuser,   // kind[1:0]
  // stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  output logic         m_tlast,   // last_point
  output logic         m_tuser,   // error_flag
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import plars_pkg::*;

  typedef enum logic [22:0] {
    ST_IDLE = 23'd1 << 0,
    ST_RD0  = 23'd1 << 1,
    ST_CAP0 = 23'd1 << 2,
    ST_RDN  = 23'd1 << 3,
    ST_SQ0  = 23'd1 << 4,
    ST_SQ1  = 23'd1 << 5,
    ST_SQ2  = 23'd1 << 6,
    ST_SQ3  = 23'd1 << 7,
    ST_SQW  = 23'd1 << 8,
    ST_OUT  = 23'd1 << 9,
    ST_TDIV = 23'd1 << 10,
    ST_TDW  = 23'd1 << 11,
    ST_SCAN = 23'd1 << 12,
    ST_SCHK = 23'd1 << 13,
    ST_FDW  = 23'd1 << 14,
    ST_RDA  = 23'd1 << 15,
    ST_RDB  = 23'd1 << 16,
    ST_MX   = 23'd1 << 17,
    ST_MY   = 23'd1 << 18,
    ST_MZ   = 23'd1 << 19,
    ST_MEND = 23'd1 << 20,
    ST_LRD  = 23'd1 << 21,
    ST_LCAP = 23'd1 << 22
  } state_t;

  state_t state;

  // configuration
  logic [PcW-1:0] point_count;

  // stores
  node_t           node_mem [MaxNodes];
  logic [SegW-1:0] slen_mem [MaxNodes];
  node_t           node_q;
  logic [SegW-1:0] slen_q;
  logic [CountW-1:0] node_count;

  // run state
  logic [JW-1:0]   nm1;      // point_count - 1 after saturation
  logic [JW-1:0]   j;
  logic [NodeAw-1:0] seg;
  logic [TotW-1:0] total;
  logic [TotW-1:0] cum;
  logic [TotW-1:0] tgt;
  logic [NumW-1:0] num;
  logic [FracBits:0] frac;
  logic [64:0]     acc;
  logic            lfin;
  node_t           prev;
  node_t           out_pt;
  logic            out_last;
  logic            out_err;

  // shared units
  logic [CoordW-1:0]   mul_a, mul_b;
  logic [2*CoordW-1:0] prod;
  iter_ctl_t           ictl;
  logic [RadW-1:0]     ia;
  logic [SegW-1:0]     ib;
  logic                idone;
  logic [DvdW-1:0]     iq;

  // combinational helpers
  logic              in_acc;
  kind_t             kind;
  logic [NodeAw-1:0] rd_addr;
  logic              rd_en;
  logic [NodeAw-1:0] last_idx;
  logic signed [CoordW:0] dx, dy, dz;
  logic [CoordW-1:0] off;
  logic              neg;
  logic signed [CoordW+1:0] base;
  logic signed [CoordW+1:0] pnt;
  logic [TotW:0]     ends;
  logic              found;
  logic [TotW-1:0]   rdist;
  logic [JW-1:0]     jn;

  assign kind     = kind_t'(s_tuser);
  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = out_pt;
  assign m_tlast  = out_last;
  assign m_tuser  = out_err;
  assign last_idx = NodeAw'(node_count - CountW'(1));
  assign jn       = j + JW'(1);

  // register port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32-PcW){1'b0}}, point_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PcMin;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      point_count <= pwdata[PcW-1:0];
    end
  end

  // component differences of the node pair held in prev / node_q
  assign dx = {node_q.x[CoordW-1], node_q.x} - {prev.x[CoordW-1], prev.x};
  assign dy = {node_q.y[CoordW-1], node_q.y} - {prev.y[CoordW-1], prev.y};
  assign dz = {node_q.z[CoordW-1], node_q.z} - {prev.z[CoordW-1], prev.z};

  always_comb begin
    unique case (state)
      ST_SQ1, ST_MY: mul_a = mag(dy);
      ST_SQ2, ST_MZ: mul_a = mag(dz);
      default:       mul_a = mag(dx);
    endcase
    mul_b = (state == ST_MX || state == ST_MY || state == ST_MZ)
            ? {{(CoordW-FracBits-1){1'b0}}, frac} : mul_a;
  end

  // interpolation: the product finished this cycle belongs to the previous component
  always_comb begin
    off = prod[FracBits+CoordW-1:FracBits];
    unique case (state)
      ST_MY: begin
        neg  = dx[CoordW];
        base = {{2{prev.x[CoordW-1]}}, prev.x};
      end
      ST_MZ: begin
        neg  = dy[CoordW];
        base = {{2{prev.y[CoordW-1]}}, prev.y};
      end
      default: begin
        neg  = dz[CoordW];
        base = {{2{prev.z[CoordW-1]}}, prev.z};
      end
    endcase
    pnt = neg ? base - $signed({2'b00, off}) : base + $signed({2'b00, off});
  end

  // segment walk: first nonzero segment whose end reaches the target distance
  assign ends  = {1'b0, cum} + {{(TotW+1-SegW){1'b0}}, slen_q};
  assign found = (slen_q != '0) && ({1'b0, tgt} <= ends);
  assign rdist = tgt - cum;

  // shared divide / root unit control
  always_comb begin
    ictl = '{start: 1'b0, op: OP_DIV};
    ia   = '0;
    ib   = '0;
    unique case (state)
      ST_SQ3: begin
        ictl = '{start: 1'b1, op: OP_SQRT};
        ia   = {1'b0, acc} + {2'b00, prod};
      end
      ST_TDIV: begin
        ictl = '{start: 1'b1, op: OP_DIV};
        ia   = {{(RadW-NumW){1'b0}}, num};
        ib   = {{(SegW-JW){1'b0}}, nm1};
      end
      ST_SCHK: begin
        ictl = '{start: found, op: OP_DIV};
        ia   = {2'b00, rdist[SegW:0], {FracBits{1'b0}}};
        ib   = slen_q;
      end
      default: ;
    endcase
  end

  // node store read address
  always_comb begin
    rd_en   = 1'b1;
    unique case (state)
      ST_RD0:         rd_addr = '0;
      ST_RDN, ST_RDB: rd_addr = seg + NodeAw'(1);
      ST_RDA:         rd_addr = seg;
      ST_LRD:         rd_addr = last_idx;
      default: begin
        rd_en   = 1'b0;
        rd_addr = seg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_APPEND && !node_count[CountW-1]) begin
      node_mem[node_count[NodeAw-1:0]] <= s_tdata;
    end
    if (rd_en) begin
      node_q <= node_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SQW && idone) begin
      slen_mem[seg] <= iq[SegW-1:0];
    end
    if (state == ST_SCAN) begin
      slen_q <= slen_mem[seg];
    end
  end

  plars_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  plars_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ictl),
    .a    (ia),
    .b    (ib),
    .done (idone),
    .q    (iq)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (kind)
              KIND_APPEND: begin
                if (!node_count[CountW-1]) node_count <= node_count + CountW'(1);
              end
              KIND_CLEAR: node_count <= '0;
              KIND_RESAMPLE: begin
                if (point_count < PcMin)      nm1 <= JW'(PcMin - 7'd1);
                else if (point_count > PcMax) nm1 <= JW'(PcMax - 7'd1);
                else                          nm1 <= JW'(point_count - 7'd1);
                seg   <= '0;
                total <= '0;
                if (node_count < CountW'(2)) begin
                  // too few nodes: one zero point flagged as error
                  out_pt   <= '0;
                  out_last <= 1'b1;
                  out_err  <= 1'b1;
                  state    <= ST_OUT;
                end else begin
                  state <= ST_RD0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD0: state <= ST_CAP0;
        ST_CAP0: begin
          // node 0 is both the first output and the start of segment 0
          prev     <= node_q;
          out_pt   <= node_q;
          out_last <= 1'b0;
          out_err  <= 1'b0;
          state    <= ST_RDN;
        end
        ST_RDN: state <= ST_SQ0;
        ST_SQ0: state <= ST_SQ1;
        ST_SQ1: begin
          acc   <= {1'b0, prod};
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          acc   <= acc + {1'b0, prod};
          state <= ST_SQ3;
        end
        ST_SQ3: state <= ST_SQW;
        ST_SQW: begin
          if (idone) begin
            total <= total + {{(TotW-SegW){1'b0}}, iq[SegW-1:0]};
            prev  <= node_q;
            if (seg + NodeAw'(1) == last_idx) begin
              seg   <= '0;
              cum   <= '0;
              j     <= '0;
              num   <= '0;
              state <= ST_OUT;
            end else begin
              seg   <= seg + NodeAw'(1);
              state <= ST_RDN;
            end
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              j   <= jn;
              num <= num + {{(NumW-TotW){1'b0}}, total};
              if (jn == nm1) begin
                lfin  <= 1'b1;
                state <= ST_LRD;
              end else begin
                state <= ST_TDIV;
              end
            end
          end
        end
        ST_TDIV: state <= ST_TDW;
        ST_TDW: begin
          if (idone) begin
            tgt   <= iq[TotW-1:0];
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // walked past every segment: the point is the last node
          if ({1'b0, seg} == node_count - CountW'(1)) begin
            lfin  <= 1'b0;
            state <= ST_LRD;
          end else begin
            state <= ST_SCHK;
          end
        end
        ST_SCHK: begin
          if (found) begin
            state <= ST_FDW;
          end else begin
            cum   <= ends[TotW-1:0];
            seg   <= seg + NodeAw'(1);
            state <= ST_SCAN;
          end
        end
        ST_FDW: begin
          if (idone) begin
            frac  <= iq[FracBits:0];
            state <= ST_RDA;
          end
        end
        ST_RDA: state <= ST_RDB;
        ST_RDB: begin
          prev  <= node_q;
          state <= ST_MX;
        end
        ST_MX: state <= ST_MY;
        ST_MY: begin
          out_pt.x <= pnt[CoordW-1:0];
          state    <= ST_MZ;
        end
        ST_MZ: begin
          out_pt.y <= pnt[CoordW-1:0];
          state    <= ST_MEND;
        end
        ST_MEND: begin
          out_pt.z <= pnt[CoordW-1:0];
          out_last <= 1'b0;
          state    <= ST_OUT;
        end
        ST_LRD: state <= ST_LCAP;
        ST_LCAP: begin
          out_pt   <= node_q;
          out_last <= lfin;
          state    <= ST_OUT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/plars_chk.sv @@
// Port-level checks for the polyline resampler, bound to the top level.
// Depends on plars_pkg for the beat kind codes and on the top level's ports.
module plars_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);
  import plars_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output beat changed");

  // no new input while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while output pending");

  // an error result is always the only and last beat of its run
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error beat without tlast");

  // append, clear and unused kinds leave the block ready again in the next cycle
  a_quick_kinds: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != KIND_RESAMPLE |=> s_tready && !m_tvalid)
    else $error("non-resample beat stalled the block");

endmodule

bind polyline_arc_length_resample_top plars_chk u_plars_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

@@ dv/tb_polyline_arc_length_resample_top.sv @@
// Self-checking testbench for the polyline arc-length resampler top level.
// Depends on plars_pkg and polyline_arc_length_resample_top; drives node,
// clear and resample beats, programs point_count over APB, checks every point.
module tb_polyline_arc_length_resample_top;
  import plars_pkg::*;

  localparam int StallLimit = 200000;
  localparam logic [2:0] AddrPointCount = 3'd0;

  // one expected output point
  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        last;
    logic        err;
  } point_t;

  // one directed row: kind, coordinates, and an optional typed-in first point
  typedef struct {
    kind_t       kind;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    bit          typed;
    point_t      want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // model state of the block
  logic signed [31:0] nodes_x[MaxNodes];
  logic signed [31:0] nodes_y[MaxNodes];
  logic signed [31:0] nodes_z[MaxNodes];
  int unsigned        node_cnt;
  logic [6:0]         pts_reg;
  longint unsigned    seg_lens[MaxNodes];

  point_t pending_pts[$];
  row_t   rows[$];
  int     err_count;
  int     idle_pct;
  int     stall_pct;
  int     quiet_cycles;

  polyline_arc_length_resample_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    err_count++;
  endtask

  // queue one expected point behind the others
  task automatic expect_point(input point_t p);
    pending_pts.insert(pending_pts.size(), p);
  endtask

  // add one directed row to the table
  task automatic add_row(input kind_t k, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] z, input bit typed, input point_t want);
    row_t r;
    r.kind  = k;
    r.cx    = x;
    r.cy    = y;
    r.cz    = z;
    r.typed = typed;
    r.want  = want;
    rows.insert(rows.size(), r);
  endtask

  // floor of the square root of a 128-bit sum of squares, bit by bit
  function automatic longint unsigned isqrt(input logic [127:0] v);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[63:0];
  endfunction

  function automatic longint unsigned span_of(input int i);
    logic signed [63:0] d[3];
    logic [127:0] acc;
    d[0] = 64'(nodes_x[i+1]) - 64'(nodes_x[i]);
    d[1] = 64'(nodes_y[i+1]) - 64'(nodes_y[i]);
    d[2] = 64'(nodes_z[i+1]) - 64'(nodes_z[i]);
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc += 128'(d[k] < 0 ? -d[k] : d[k]) * 128'(d[k] < 0 ? -d[k] : d[k]);
    end
    return isqrt(acc);
  endfunction

  // move from node a toward node a+1 by fraction f (Q1.30)
  function automatic logic [31:0] lerp(input logic signed [31:0] a,
                                       input logic signed [31:0] b,
                                       input longint unsigned f);
    logic signed [63:0] d;
    logic [95:0] prod;
    logic signed [63:0] off;
    d = 64'(b) - 64'(a);
    prod = 96'(d < 0 ? -d : d) * 96'(f);
    off = 64'(prod >> FracBits);
    return 32'(64'(a) + (d < 0 ? -off : off));
  endfunction

  function automatic point_t place_at(input longint unsigned t);
    point_t p;
    longint unsigned cum;
    longint unsigned s;
    longint unsigned r;
    longint unsigned f;
    cum = 0;
    for (int i = 0; i + 1 < node_cnt; i++) begin
      s = seg_lens[i];
      if (s != 0 && t <= cum + s) begin
        r = t - cum;
        f = 0;
        if (r >= s) begin
          f = 64'd1 << FracBits;
        end else begin
          for (int b = 0; b < FracBits; b++) begin
            r = r << 1;
            f = f << 1;
            if (r >= s) begin
              r -= s;
              f |= 1;
            end
          end
        end
        p.px = lerp(nodes_x[i], nodes_x[i+1], f);
        p.py = lerp(nodes_y[i], nodes_y[i+1], f);
        p.pz = lerp(nodes_z[i], nodes_z[i+1], f);
        p.last = 1'b0;
        p.err = 1'b0;
        return p;
      end
      cum += s;
    end
    p.px = nodes_x[node_cnt-1];
    p.py = nodes_y[node_cnt-1];
    p.pz = nodes_z[node_cnt-1];
    p.last = 1'b0;
    p.err = 1'b0;
    return p;
  endfunction

  // update the node model for one accepted beat and queue the points it yields
  task automatic predict_points(input kind_t kind, input logic [95:0] data);
    longint unsigned n;
    longint unsigned total;
    point_t p;
    case (kind)
      KIND_APPEND: begin
        if (node_cnt < MaxNodes) begin
          nodes_x[node_cnt] = data[31:0];
          nodes_y[node_cnt] = data[63:32];
          nodes_z[node_cnt] = data[95:64];
          node_cnt++;
        end
      end
      KIND_CLEAR: node_cnt = 0;
      KIND_RESAMPLE: begin
        n = pts_reg;
        if (n < PcMin) n = PcMin;
        if (n > PcMax) n = PcMax;
        if (node_cnt < 2) begin
          p = '{32'd0, 32'd0, 32'd0, 1'b1, 1'b1};
          expect_point(p);
        end else begin
          total = 0;
          for (int i = 0; i + 1 < node_cnt; i++) begin
            seg_lens[i] = span_of(i);
            total += seg_lens[i];
          end
          p = '{nodes_x[0], nodes_y[0], nodes_z[0], 1'b0, 1'b0};
          expect_point(p);
          for (longint unsigned j = 1; j + 1 < n; j++) begin
            expect_point(place_at((j * total) / (n - 1)));
          end
          p = '{nodes_x[node_cnt-1], nodes_y[node_cnt-1], nodes_z[node_cnt-1], 1'b1, 1'b0};
          expect_point(p);
        end
      end
      default: ;
    endcase
  endtask

  // send one beat, idling first at the chosen rate; returns once accepted
  task automatic send_beat(input kind_t kind, input logic [95:0] data);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    predict_points(kind, data);
    @(negedge clk);
  endtask

  // drop valid, let all expected points drain, then give the block time to settle
  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_points(input logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= AddrPointCount;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pts_reg = v[6:0];
  endtask

  function automatic logic [95:0] rand_node(input int spread);
    logic [31:0] c[3];
    for (int k = 0; k < 3; k++) begin
      case (spread)
        0: c[k] = $urandom;
        1: c[k] = 32'($signed($urandom_range(2000)) - 1000) <<< 16;
        default: c[k] = 32'($signed($urandom_range(200000)) - 100000);
      endcase
    end
    return {c[2], c[1], c[0]};
  endfunction

  // receiver: stall at random, check each point against the oldest expectation
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pts.size() == 0) begin
        report("unexpected point", m_tdata[31:0], 32'd0);
      end else begin
        want = pending_pts.pop_front();
        if (m_tdata[31:0] !== want.px) report("point_x", m_tdata[31:0], want.px);
        if (m_tdata[63:32] !== want.py) report("point_y", m_tdata[63:32], want.py);
        if (m_tdata[95:64] !== want.pz) report("point_z", m_tdata[95:64], want.pz);
        if (m_tlast !== want.last) report("last_point", 32'(m_tlast), 32'(want.last));
        if (m_tuser !== want.err) report("error_flag", 32'(m_tuser), 32'(want.err));
      end
    end
  end

  // watchdog: count cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_polyline_arc_length_resample_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    point_t  p;
    point_t  ptyped;
    int      phase;
    int      runs;
    int      nn;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_NONE;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    node_cnt = 0;
    pts_reg = PcMin;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows: error run on an empty store, extremes, zero-length segments
    add_row(KIND_RESAMPLE, 0, 0, 0, 1, '{0, 0, 0, 1, 1});
    add_row(KIND_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_RESAMPLE, 0, 0, 0, 1, '{0, 0, 0, 1, 1});
    add_row(KIND_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_RESAMPLE, 0, 0, 0, 1,
            '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0});
    add_row(KIND_CLEAR, 0, 0, 0, 0, '{0, 0, 0, 0, 0});
    add_row(KIND_APPEND, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_APPEND, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_RESAMPLE, 0, 0, 0, 1,
            '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0});
    add_row(KIND_APPEND, 32'h0005_0000, 32'h0002_0000, 32'h0003_0000, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_APPEND, 32'h0005_0000, 32'h0002_0000, 32'h0003_0000, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_APPEND, 32'h0005_0000, 32'hfffe_0000, 32'h0003_0000, 0,
            '{0, 0, 0, 0, 0});
    add_row(KIND_RESAMPLE, 0, 0, 0, 0, '{0, 0, 0, 0, 0});
    add_row(KIND_CLEAR, 0, 0, 0, 0, '{0, 0, 0, 0, 0});
    add_row(KIND_RESAMPLE, 0, 0, 0, 1, '{0, 0, 0, 1, 1});

    for (int r = 0; r < rows.size(); r++) begin
      // the row between zero-length segments runs with a finer count
      if (r == 14) begin
        drain();
        write_points(32'd9);
      end
      nn = pending_pts.size();
      send_beat(rows[r].kind, {rows[r].cz, rows[r].cy, rows[r].cx});
      if (rows[r].typed) begin
        p = pending_pts[nn];
        ptyped = rows[r].want;
        if (p.px !== ptyped.px || p.err !== ptyped.err || (p.err && p.last !== ptyped.last))
          report("typed row", p.px, ptyped.px);
      end
    end
    drain();

    // random phases: point_count sweeps extremes and out-of-range values
    for (phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: write_points(32'd64);
        1: write_points(32'd2);
        2: write_points(32'd0);
        3: write_points(32'd127);
        4: write_points(32'd1);
        5: write_points(32'h7f);
        default: write_points($urandom_range(2, 40));
      endcase
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      runs = 0;
      while (runs < 3) begin
        // mostly well-formed polylines, sometimes short or noisy ones
        nn = $urandom_range(99) < 15 ? $urandom_range(0, 1) : $urandom_range(2, 5);
        if ($urandom_range(99) < 80) send_beat(KIND_CLEAR, rand_node(0));
        for (int k = 0; k < nn; k++) begin
          if ($urandom_range(99) < 10 && k > 0) begin
            send_beat(KIND_APPEND, {nodes_z[node_cnt-1], nodes_y[node_cnt-1],
                                    nodes_x[node_cnt-1]});
          end else begin
            send_beat(KIND_APPEND, rand_node($urandom_range(2)));
          end
        end
        if ($urandom_range(99) < 8) send_beat(KIND_NONE, rand_node(0));
        send_beat(KIND_RESAMPLE, rand_node(0));
        runs++;
      end
    end
    drain();

    if (err_count == 0) begin
      $display("tb_polyline_arc_length_resample_top: done, clean");
    end else begin
      $display("tb_polyline_arc_length_resample_top: done, errors");
    end
    $finish;
  end

endmodule

@@ polyline_arc_length_resample_top.f @@
rtl/plars_pkg.sv
rtl/plars_mul.sv
rtl/plars_iter.sv
rtl/polyline_arc_length_resample_top.sv
rtl/plars_chk.sv
dv/tb_polyline_arc_length_resample_top.sv
